>>> rtl/mvcc_pkg.sv
package mvcc_pkg;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_CLAIM  = 2'd1,
    ACT_VIS    = 2'd2,
    ACT_STATUS = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_ACTIVE    = 2'd0,
    ST_COMMITTED = 2'd1,
    ST_ABORTED   = 2'd2,
    ST_UNUSED    = 2'd3
  } txn_state_t;

  typedef enum logic [1:0] {
    OUT_OK        = 2'd0,
    OUT_CONFLICT  = 2'd1,
    OUT_NOT_FOUND = 2'd2,
    OUT_FULL      = 2'd3
  } outcome_t;

  localparam int unsigned FIFO_DEPTH = 2;

endpackage

>>> rtl/mvcc_ram.sv
module mvcc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/mvcc_front.sv
module mvcc_front #(
  parameter int unsigned W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  output logic         full,
  input  logic [W-1:0] din,
  output logic         q_valid,
  input  logic         q_take,
  output logic [W-1:0] q_data
);

  localparam int unsigned AW = $clog2(mvcc_pkg::FIFO_DEPTH);

  logic [W-1:0] slots [mvcc_pkg::FIFO_DEPTH];
  logic [AW-1:0] wptr;
  logic [AW-1:0] rptr;
  logic [AW:0] count;
  logic do_push;
  logic do_pop;

  assign full = rst || (count == (AW+1)'(mvcc_pkg::FIFO_DEPTH));
  assign q_valid = (count != '0);
  assign q_data = slots[rptr];
  assign do_push = push && !full;
  assign do_pop = q_take && q_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= din;
    end
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (do_push) wptr <= wptr + 1'b1;
      if (do_pop) rptr <= rptr + 1'b1;
      count <= count + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end
  end

endmodule

>>> rtl/mvcc_back.sv
module mvcc_back #(
  parameter int unsigned VERSION_DEPTH = 64,
  parameter int unsigned TXN_ID_BITS = 8,
  parameter int unsigned TIME_BITS = 32,
  parameter int unsigned ROW_ID_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_valid,
  output logic                   q_take,
  input  logic [1:0]             act,
  input  logic [ROW_ID_BITS-1:0] row,
  input  logic [TXN_ID_BITS-1:0] txn,
  input  logic [TIME_BITS-1:0]   snap,
  input  logic                   base,
  input  logic [TXN_ID_BITS-1:0] cre,
  input  logic [TXN_ID_BITS-1:0] del,
  input  logic [1:0]             nst,
  input  logic [TIME_BITS-1:0]   ctime,
  output logic                   res_valid,
  input  logic                   res_take,
  output logic [1:0]             res_outcome,
  output logic                   res_visible
);

  localparam int unsigned VA = $clog2(VERSION_DEPTH);
  localparam int unsigned TXN_COUNT = 1 << TXN_ID_BITS;
  localparam int unsigned SW = 2 + TIME_BITS;

  typedef enum logic [7:0] {
    S_CLEAR  = 8'b00000001,
    S_IDLE   = 8'b00000010,
    S_VLOOK1 = 8'b00000100,
    S_VLOOK2 = 8'b00001000,
    S_VEVAL  = 8'b00010000,
    S_SREAD  = 8'b00100000,
    S_SEVAL  = 8'b01000000,
    S_DONE   = 8'b10000000
  } state_t;

  state_t state;
  logic [TXN_ID_BITS-1:0] clr_idx;
  logic [VA:0] vcount;
  logic [VA:0] scan;
  logic touched;

  // status ram
  logic st_we;
  logic [TXN_ID_BITS-1:0] st_waddr;
  logic [SW-1:0] st_wdata;
  logic [TXN_ID_BITS-1:0] st_raddr;
  logic [SW-1:0] st_rdata;

  mvcc_ram #(.WIDTH(SW), .DEPTH(TXN_COUNT)) u_status (
    .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
    .raddr(st_raddr), .rdata(st_rdata)
  );

  // version ram: row, creator, deleter, tombstone
  localparam int unsigned VW = ROW_ID_BITS + 2*TXN_ID_BITS + 1;
  logic v_we;
  logic [VA-1:0] v_waddr;
  logic [VW-1:0] v_wdata;
  logic [VA-1:0] v_raddr;
  logic [VW-1:0] v_rdata;

  mvcc_ram #(.WIDTH(VW), .DEPTH(VERSION_DEPTH)) u_version (
    .clk(clk), .we(v_we), .waddr(v_waddr), .wdata(v_wdata),
    .raddr(v_raddr), .rdata(v_rdata)
  );

  logic [ROW_ID_BITS-1:0] v_row;
  logic [TXN_ID_BITS-1:0] v_cre;
  logic [TXN_ID_BITS-1:0] v_del;
  assign v_row = v_rdata[VW-1 -: ROW_ID_BITS];
  assign v_cre = v_rdata[2*TXN_ID_BITS : TXN_ID_BITS+1];
  assign v_del = v_rdata[TXN_ID_BITS:1];

  // held lookups: entry and creator status; deleter status is used as read
  logic [VW-1:0] ent;
  logic [TXN_ID_BITS-1:0] ecre;
  logic [TXN_ID_BITS-1:0] edel;
  logic [1:0] c_st;
  logic [TIME_BITS-1:0] c_tm;
  assign ecre = ent[2*TXN_ID_BITS : TXN_ID_BITS+1];
  assign edel = ent[TXN_ID_BITS:1];

  logic c_comm;
  logic d_comm;
  logic created;
  logic del_vis;
  logic vis_ok;
  assign c_comm = (c_st == mvcc_pkg::ST_COMMITTED) && (c_tm <= snap);
  assign d_comm = (st_rdata[SW-1 -: 2] == mvcc_pkg::ST_COMMITTED)
                  && (st_rdata[TIME_BITS-1:0] <= snap);
  assign created = (ecre == '0) || (ecre == txn) || c_comm;
  assign del_vis = (edel == txn) || d_comm;
  assign vis_ok = created && ((edel == '0) || !del_vis);

  logic [1:0] fin_out;
  logic fin_vis;
  logic [TXN_ID_BITS-1:0] lookup;
  logic tbl_full;
  assign tbl_full = (vcount == (VA+1)'(VERSION_DEPTH));

  always_comb begin
    st_we = 1'b0;
    st_waddr = txn;
    st_wdata = {mvcc_pkg::ST_ABORTED, ctime};
    lookup = ecre;
    v_we = 1'b0;
    v_waddr = vcount[VA-1:0];
    v_wdata = {row, cre, {TXN_ID_BITS{1'b0}}, 1'b0};
    v_raddr = scan[VA-1:0] - 1'b1;
    unique case (state)
      S_CLEAR: begin
        st_we = 1'b1;
        st_waddr = clr_idx;
        st_wdata = {mvcc_pkg::ST_ABORTED, {TIME_BITS{1'b0}}};
      end
      S_IDLE: begin
        if (q_valid && act == mvcc_pkg::ACT_STATUS) begin
          st_we = 1'b1;
          st_wdata = {(nst == mvcc_pkg::ST_UNUSED) ? mvcc_pkg::ST_ABORTED : nst, ctime};
        end
        if (q_valid && act == mvcc_pkg::ACT_INSERT && !tbl_full) v_we = 1'b1;
        lookup = cre;
      end
      S_VLOOK1: lookup = v_cre;
      S_VLOOK2: lookup = edel;
      S_VEVAL: begin
        if (touched == 1'b0 && scan == '0 && base && !tbl_full
            && act == mvcc_pkg::ACT_CLAIM) begin
          v_we = 1'b1;
          v_wdata = {row, {TXN_ID_BITS{1'b0}}, txn, 1'b1};
        end
      end
      S_SREAD: lookup = edel;
      S_SEVAL: begin
        v_waddr = scan[VA-1:0];
        v_wdata = {ent[VW-1 -: ROW_ID_BITS], ecre, txn, ent[0]};
        // claim the version when checks pass
        if (act == mvcc_pkg::ACT_CLAIM &&
            !(edel != '0 && edel != txn && st_rdata[SW-1 -: 2] ==
              mvcc_pkg::ST_ACTIVE) && !(edel != '0 && edel != txn &&
              st_rdata[SW-1 -: 2] == mvcc_pkg::ST_COMMITTED) &&
            !(edel == txn) && vis_ok) v_we = 1'b1;
      end
      default: ;
    endcase
    st_raddr = lookup;
  end

  // claim scan: VEVAL issues version read; VLOOK1 gets entry, reads creator status
  // SREAD holds creator status, reads deleter status; SEVAL decides
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_idx <= '0;
      vcount <= '0;
      res_valid <= 1'b0;
      scan <= '0;
      touched <= 1'b0;
    end else begin
      if (res_valid && res_take && state != S_DONE) res_valid <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == TXN_ID_BITS'(TXN_COUNT - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (q_valid) begin
            touched <= 1'b0;
            scan <= vcount;
            fin_vis <= 1'b0;
            fin_out <= mvcc_pkg::OUT_OK;
            unique case (act)
              mvcc_pkg::ACT_INSERT: begin
                if (tbl_full) fin_out <= mvcc_pkg::OUT_FULL;
                else vcount <= vcount + 1'b1;
                state <= S_DONE;
              end
              mvcc_pkg::ACT_CLAIM: state <= S_VEVAL;
              mvcc_pkg::ACT_VIS: begin
                ent <= {row, cre, del, 1'b0};
                state <= S_VLOOK2;
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_VLOOK1: begin
          ent <= v_rdata;
          if (v_row != row) state <= S_VEVAL;
          else begin
            touched <= 1'b1;
            state <= S_SREAD;
          end
        end
        S_SREAD: begin
          c_st <= st_rdata[SW-1 -: 2];
          c_tm <= st_rdata[TIME_BITS-1:0];
          state <= S_SEVAL;
        end
        S_VLOOK2: begin
          c_st <= st_rdata[SW-1 -: 2];
          c_tm <= st_rdata[TIME_BITS-1:0];
          state <= S_SEVAL;
        end
        S_SEVAL: begin
          if (act == mvcc_pkg::ACT_VIS) begin
            fin_vis <= vis_ok;
            state <= S_DONE;
          end else if (edel != '0 && edel != txn
                       && st_rdata[SW-1 -: 2] == mvcc_pkg::ST_ACTIVE) begin
            fin_out <= mvcc_pkg::OUT_CONFLICT;
            state <= S_DONE;
          end else if (v_we) begin
            state <= S_DONE;
          end else begin
            state <= S_VEVAL;
          end
        end
        S_VEVAL: begin
          if (scan == '0) begin
            if (!touched && base) begin
              if (tbl_full) fin_out <= mvcc_pkg::OUT_FULL;
              else vcount <= vcount + 1'b1;
            end else fin_out <= mvcc_pkg::OUT_NOT_FOUND;
            state <= S_DONE;
          end else begin
            scan <= scan - 1'b1;
            state <= S_VLOOK1;
          end
        end
        S_DONE: begin
          if (!res_valid || res_take) begin
            res_valid <= 1'b1;
            res_outcome <= fin_out;
            res_visible <= fin_vis;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // the queue head stays in place until its result is registered
  assign q_take = (state == S_DONE) && (!res_valid || res_take);

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    vcount <= (VA+1)'(VERSION_DEPTH))
    else $error("version count overflow");
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    scan <= vcount)
    else $error("scan past count");
  a_no_take_clear: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |-> !q_take)
    else $error("take during clear");
`endif

endmodule

>>> rtl/mvcc_version_claim_table.sv
// mvcc version table with transaction status store
// input side is a queue: drive fields and push while full is low
// actions: insert, claim delete, visibility check, set transaction status
// result side is a queue: outcome and visible hold while empty is low, pop takes
// a two-entry front queue decouples acceptance from the back-end engine;
// the engine works on the queue head and frees it once its result is registered
// insert and set status go from idle straight to the done state; a visibility
// check reads creator, then deleter status; a claim walks the entries newest
// to oldest, reading each entry and, for a matching row, its creator and then
// its deleter status, in turn through the single read port of each ram
// one transaction at a time: the next starts the cycle after a result registers
// reset: after rst the status ram is swept to aborted / time zero over all
// 2**TXN_ID_BITS entries, during which full stays high once the queue fills
// the version count returns to zero; full is high while rst is high
// when pop is held low the engine holds its finished result, finishes the
// next transaction and waits on it; the queue then takes one more
module mvcc_version_claim_table #(
  parameter int unsigned VERSION_DEPTH = 64,
  parameter int unsigned TXN_ID_BITS = 8,
  parameter int unsigned TIME_BITS = 32,
  parameter int unsigned ROW_ID_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  output logic                   full,
  input  logic [1:0]             action,
  input  logic [ROW_ID_BITS-1:0] row_key,
  input  logic [TXN_ID_BITS-1:0] txn_ident,
  input  logic [TIME_BITS-1:0]   snapshot_time,
  input  logic                   in_base,
  input  logic [TXN_ID_BITS-1:0] creator_ident,
  input  logic [TXN_ID_BITS-1:0] deleter_ident,
  input  logic [1:0]             new_state,
  input  logic [TIME_BITS-1:0]   commit_time,
  output logic                   empty,
  input  logic                   pop,
  output logic [1:0]             outcome,
  output logic                   visible
);

  localparam int unsigned QW = 2 + ROW_ID_BITS + 3*TXN_ID_BITS + 2*TIME_BITS + 3;

  logic q_valid;
  logic q_take;
  logic [QW-1:0] q_data;
  logic res_valid;

  mvcc_front #(.W(QW)) u_front (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .din({action, row_key, txn_ident, snapshot_time, in_base, creator_ident,
          deleter_ident, new_state, commit_time}),
    .q_valid(q_valid), .q_take(q_take), .q_data(q_data)
  );

  mvcc_back #(
    .VERSION_DEPTH(VERSION_DEPTH), .TXN_ID_BITS(TXN_ID_BITS),
    .TIME_BITS(TIME_BITS), .ROW_ID_BITS(ROW_ID_BITS)
  ) u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_take(q_take),
    .act(q_data[QW-1 -: 2]),
    .row(q_data[QW-3 -: ROW_ID_BITS]),
    .txn(q_data[QW-3-ROW_ID_BITS -: TXN_ID_BITS]),
    .snap(q_data[QW-3-ROW_ID_BITS-TXN_ID_BITS -: TIME_BITS]),
    .base(q_data[2*TXN_ID_BITS + 2 + TIME_BITS]),
    .cre(q_data[2*TXN_ID_BITS + 1 + TIME_BITS -: TXN_ID_BITS]),
    .del(q_data[TXN_ID_BITS + 1 + TIME_BITS -: TXN_ID_BITS]),
    .nst(q_data[TIME_BITS+1 -: 2]),
    .ctime(q_data[TIME_BITS-1:0]),
    .res_valid(res_valid), .res_take(pop),
    .res_outcome(outcome), .res_visible(visible)
  );

  assign empty = !res_valid;

endmodule
